// ===== rtl/core/mwq_pkg.sv =====
// Shared types and constants for the mailbox with waiter queue.
`timescale 1ns / 1ps
`default_nettype none

package mwq_pkg;

    // Waiter queue geometry
    localparam int WAITER_SLOTS = 16;
    localparam int WIDX_W       = $clog2(WAITER_SLOTS);
    localparam int WCNT_W       = $clog2(WAITER_SLOTS + 1);

    // Command queue between front and back
    localparam int CQ_DEPTH = 2;
    localparam int CQ_IDX_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    localparam int TID_W = 6;
    localparam int VAL_W = 32;

    typedef enum logic [1:0] {
        CMD_SEND  = 2'd0,
        CMD_BCAST = 2'd1,
        CMD_RECV  = 2'd2,
        CMD_BAD   = 2'd3
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_DELIVERED  = 3'd0,
        ST_STORED     = 3'd1,
        ST_SLOT_FULL  = 3'd2,
        ST_NO_WAITERS = 3'd3,
        ST_BLOCKED    = 3'd4,
        ST_QUEUE_FULL = 3'd5
    } status_t;

    typedef enum logic {
        EX_IDLE  = 1'b0,
        EX_BCAST = 1'b1
    } ex_state_t;

    // One classified command as queued between front and back
    typedef struct packed {
        cmd_code_t          cmd;
        logic [TID_W-1:0]   tid;
        logic [VAL_W-1:0]   value;
    } cmd_t;

    // One result item
    typedef struct packed {
        status_t            status;
        logic               dv;
        logic [TID_W-1:0]   target;
        logic [VAL_W-1:0]   value;
        logic               last;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/mailbox_with_waiter_queue_top.sv =====
// Top level of the mailbox with waiter queue: front queue and back end.
//
//   Channel  Dir  Handshake          Payload
//   s_       in   s_tvalid/s_tready  tuser: command; tdata: thread_id, message_value
//   m_       out  m_tvalid/m_tready  tuser: status, delivery_valid; tdata: target_thread,
//                                    delivered_value; tlast: last
//
// The back end executes one command per cycle unless stalled by the output or a broadcast.
// A broadcast yields one result per waiter; a command is queued, then registered for output.
// A two-entry command queue lets the front keep taking transfers while the back stalls.
// aresetn (synchronous, active low) empties the slot, the waiter queue and both queues.
// m_tready low holds the output register and stops the back end.
`timescale 1ns / 1ps
`default_nettype none

module mailbox_with_waiter_queue_top (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [39:0]   s_tdata,   // [5:0] thread_id, [37:6] message_value, [39:38] zero
    input  wire logic [1:0]    s_tuser,   // [1:0] command
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [39:0]        m_tdata,   // [5:0] target_thread, [37:6] delivered_value, zero
    output logic [3:0]         m_tuser,   // [2:0] status, [3] delivery_valid
    output logic               m_tlast
);

    logic           q_valid;
    logic           q_ready;
    mwq_pkg::cmd_t  q_cmd;
    mwq_pkg::res_t  res;

    mwq_cmd_fifo u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_tid    (s_tdata[5:0]),
        .in_value  (s_tdata[37:6]),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    mwq_exec u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result transfer
    assign m_tdata = {2'b00, res.value, res.target};
    assign m_tuser = {res.dv, res.status};
    assign m_tlast = res.last;

endmodule

`default_nettype wire

// ===== rtl/core/mwq_cmd_fifo.sv =====
// Front end: accepts commands, decodes them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module mwq_cmd_fifo (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           in_cmd,
    input  wire logic [5:0]           in_tid,
    input  wire logic [31:0]          in_value,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output mwq_pkg::cmd_t             out_cmd
);

    mwq_pkg::cmd_t                    entry_reg [mwq_pkg::CQ_DEPTH];
    logic [mwq_pkg::CQ_IDX_W-1:0]     wr_ptr_reg;
    logic [mwq_pkg::CQ_IDX_W-1:0]     rd_ptr_reg;
    logic [mwq_pkg::CQ_CNT_W-1:0]     count_reg;
    mwq_pkg::cmd_t                    in_item;
    logic                             push;
    logic                             pop;

    // Classify the incoming transfer
    always_comb begin
        in_item.cmd   = mwq_pkg::cmd_code_t'(in_cmd);
        in_item.tid   = in_tid;
        in_item.value = in_value;
    end

    assign in_ready  = (count_reg != mwq_pkg::CQ_CNT_W'(mwq_pkg::CQ_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == mwq_pkg::CQ_IDX_W'(mwq_pkg::CQ_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == mwq_pkg::CQ_IDX_W'(mwq_pkg::CQ_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mwq_exec.sv =====
// Back end: mailbox slot, waiter queue, broadcast sequencer and output register.
`timescale 1ns / 1ps
`default_nettype none

module mwq_exec (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cmd_valid,
    output logic                      cmd_ready,
    input  wire mwq_pkg::cmd_t        cmd,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output mwq_pkg::res_t             res
);

    mwq_pkg::ex_state_t               state_reg;
    mwq_pkg::ex_state_t               state_next;

    logic [mwq_pkg::VAL_W-1:0]        slot_value_reg;
    logic                             slot_full_reg;
    logic [mwq_pkg::TID_W-1:0]        waiter_ids_reg [mwq_pkg::WAITER_SLOTS];
    logic [mwq_pkg::WIDX_W-1:0]       head_reg;
    logic [mwq_pkg::WIDX_W-1:0]       tail_reg;
    logic [mwq_pkg::WCNT_W-1:0]       count_reg;
    logic [mwq_pkg::VAL_W-1:0]        bval_reg;

    logic                             out_valid_reg;
    mwq_pkg::res_t                    out_reg;
    mwq_pkg::res_t                    res_next;

    logic                             out_free;
    logic                             load_out;
    logic                             pop;
    logic                             push;
    logic                             slot_set;
    logic                             slot_clr;
    logic                             bval_load;
    logic                             one_left;
    logic                             queue_full;
    logic [mwq_pkg::TID_W-1:0]        head_id;

    assign out_free   = !out_valid_reg || res_ready;
    assign one_left   = (count_reg == mwq_pkg::WCNT_W'(1));
    assign queue_full = (count_reg == mwq_pkg::WCNT_W'(mwq_pkg::WAITER_SLOTS));
    assign head_id    = waiter_ids_reg[head_reg];
    assign res_valid  = out_valid_reg;
    assign res        = out_reg;

    // Next state: stay in broadcast until the last waiter goes out
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mwq_pkg::EX_IDLE: begin
                if (cmd_valid && out_free && cmd.cmd == mwq_pkg::CMD_BCAST &&
                    !slot_full_reg && count_reg > mwq_pkg::WCNT_W'(1)) begin
                    state_next = mwq_pkg::EX_BCAST;
                end
            end
            mwq_pkg::EX_BCAST: begin
                if (out_free && one_left) begin
                    state_next = mwq_pkg::EX_IDLE;
                end
            end
            default: state_next = mwq_pkg::EX_IDLE;
        endcase
    end

    // Actions and result for this cycle
    always_comb begin
        cmd_ready = 1'b0;
        load_out  = 1'b0;
        pop       = 1'b0;
        push      = 1'b0;
        slot_set  = 1'b0;
        slot_clr  = 1'b0;
        bval_load = 1'b0;
        res_next  = '0;
        res_next.last = 1'b1;
        case (state_reg)
            mwq_pkg::EX_IDLE: begin
                cmd_ready = out_free;
                if (cmd_valid && out_free) begin
                    load_out = 1'b1;
                    case (cmd.cmd)
                        mwq_pkg::CMD_SEND: begin
                            if (slot_full_reg) begin
                                res_next.status = mwq_pkg::ST_SLOT_FULL;
                            end else if (count_reg == '0) begin
                                res_next.status = mwq_pkg::ST_STORED;
                                slot_set = 1'b1;
                            end else begin
                                pop = 1'b1;
                                res_next.status = mwq_pkg::ST_DELIVERED;
                                res_next.dv     = 1'b1;
                                res_next.target = head_id;
                                res_next.value  = cmd.value;
                            end
                        end
                        mwq_pkg::CMD_BCAST: begin
                            if (slot_full_reg) begin
                                res_next.status = mwq_pkg::ST_SLOT_FULL;
                            end else if (count_reg == '0) begin
                                res_next.status = mwq_pkg::ST_NO_WAITERS;
                            end else begin
                                pop       = 1'b1;
                                bval_load = 1'b1;
                                res_next.status = mwq_pkg::ST_DELIVERED;
                                res_next.dv     = 1'b1;
                                res_next.target = head_id;
                                res_next.value  = cmd.value;
                                res_next.last   = one_left;
                            end
                        end
                        mwq_pkg::CMD_RECV: begin
                            if (slot_full_reg) begin
                                slot_clr = 1'b1;
                                res_next.status = mwq_pkg::ST_DELIVERED;
                                res_next.dv     = 1'b1;
                                res_next.target = cmd.tid;
                                res_next.value  = slot_value_reg;
                            end else if (queue_full) begin
                                res_next.status = mwq_pkg::ST_QUEUE_FULL;
                            end else begin
                                push = 1'b1;
                                res_next.status = mwq_pkg::ST_BLOCKED;
                            end
                        end
                        default: begin
                            res_next.status = mwq_pkg::ST_NO_WAITERS;
                        end
                    endcase
                end
            end
            mwq_pkg::EX_BCAST: begin
                if (out_free) begin
                    load_out = 1'b1;
                    pop      = 1'b1;
                    res_next.status = mwq_pkg::ST_DELIVERED;
                    res_next.dv     = 1'b1;
                    res_next.target = head_id;
                    res_next.value  = bval_reg;
                    res_next.last   = one_left;
                end
            end
            default: begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= res_next;
        end
        if (bval_load) begin
            bval_reg <= cmd.value;
        end
        if (slot_set) begin
            slot_value_reg <= cmd.value;
        end
        if (push) begin
            waiter_ids_reg[tail_reg] <= cmd.tid;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mwq_pkg::EX_IDLE;
            out_valid_reg <= 1'b0;
            slot_full_reg <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (slot_set) begin
                slot_full_reg <= 1'b1;
            end else if (slot_clr) begin
                slot_full_reg <= 1'b0;
            end
            // Pop the oldest waiter; an emptied queue rewinds to zero
            if (pop) begin
                count_reg <= count_reg - 1'b1;
                if (one_left) begin
                    head_reg <= '0;
                    tail_reg <= '0;
                end else begin
                    head_reg <= (head_reg == mwq_pkg::WIDX_W'(mwq_pkg::WAITER_SLOTS - 1))
                                ? '0 : head_reg + 1'b1;
                end
            end else if (push) begin
                count_reg <= count_reg + 1'b1;
                tail_reg  <= (tail_reg == mwq_pkg::WIDX_W'(mwq_pkg::WAITER_SLOTS - 1))
                             ? '0 : tail_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sim/tb_mailbox_with_waiter_queue_top.sv =====
// Self-checking testbench for the mailbox with waiter queue top level.
`timescale 1ns / 1ps

module tb_mailbox_with_waiter_queue_top;
    import mwq_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int RESET_CYCLES = 12;
    localparam int TOTAL_ITEMS  = 124;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        cmd_code_t        cmd;
        logic [TID_W-1:0] tid;
        logic [VAL_W-1:0] value;
    } mbox_cmd_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [39:0]        s_tdata;   // [5:0] thread_id, [37:6] message_value, [39:38] zero
    logic [1:0]         s_tuser;   // [1:0] command
    logic               m_tvalid;
    logic               m_tready;
    logic [39:0]        m_tdata;   // [5:0] target_thread, [37:6] delivered_value, zero
    logic [3:0]         m_tuser;   // [2:0] status, [3] delivery_valid
    logic               m_tlast;

    mailbox_with_waiter_queue_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Mirror of the mailbox state
    logic             mb_slot_full;
    logic [VAL_W-1:0] mb_slot_value;
    logic [TID_W-1:0] mb_waiters [WAITER_SLOTS];
    logic [WIDX_W-1:0] mb_head;
    logic [WIDX_W-1:0] mb_tail;
    logic [WCNT_W-1:0] mb_count;

    mbox_cmd_t pending_cmds[$];
    res_t      expected_results[$];

    int  error_count = 0;
    int  item_count  = 0;
    int  idle_cycles = 0;
    int  in_gap      = 0;
    int  out_stall   = 0;
    int  phase_cnt   = 0;
    bit  calm        = 0;
    bit  in_taken    = 0;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic res_t make_result(status_t st, logic dv, logic [TID_W-1:0] tgt,
                                         logic [VAL_W-1:0] val, logic lst);
        res_t r;
        r.status = st;
        r.dv     = dv;
        r.target = dv ? tgt : '0;
        r.value  = dv ? val : '0;
        r.last   = lst;
        return r;
    endfunction

    // Remove the oldest waiter; pointers return to zero once the queue empties
    task automatic pop_waiter(output logic [TID_W-1:0] id);
        id       = mb_waiters[mb_head];
        mb_head  = mb_head + 1'b1;
        mb_count = mb_count - 1'b1;
        if (mb_count == 0) begin
            mb_head = '0;
            mb_tail = '0;
        end
    endtask

    // Advance the mailbox mirror by one command and queue the results it yields
    task automatic predict_mailbox(input mbox_cmd_t c);
        logic [TID_W-1:0] w;
        case (c.cmd)
            CMD_SEND: begin
                if (mb_slot_full) begin
                    expected_results.push_back(make_result(ST_SLOT_FULL, 1'b0, '0, '0, 1'b1));
                end else if (mb_count == 0) begin
                    mb_slot_value = c.value;
                    mb_slot_full  = 1'b1;
                    expected_results.push_back(make_result(ST_STORED, 1'b0, '0, '0, 1'b1));
                end else begin
                    pop_waiter(w);
                    expected_results.push_back(make_result(ST_DELIVERED, 1'b1, w, c.value, 1'b1));
                end
            end
            CMD_BCAST: begin
                if (mb_slot_full) begin
                    expected_results.push_back(make_result(ST_SLOT_FULL, 1'b0, '0, '0, 1'b1));
                end else if (mb_count == 0) begin
                    expected_results.push_back(make_result(ST_NO_WAITERS, 1'b0, '0, '0, 1'b1));
                end else begin
                    while (mb_count != 0) begin
                        pop_waiter(w);
                        expected_results.push_back(make_result(ST_DELIVERED, 1'b1, w, c.value,
                                                               mb_count == 0));
                    end
                end
            end
            CMD_RECV: begin
                if (mb_slot_full) begin
                    mb_slot_full = 1'b0;
                    expected_results.push_back(make_result(ST_DELIVERED, 1'b1, c.tid,
                                                           mb_slot_value, 1'b1));
                end else if (mb_count >= WAITER_SLOTS) begin
                    expected_results.push_back(make_result(ST_QUEUE_FULL, 1'b0, '0, '0, 1'b1));
                end else begin
                    mb_waiters[mb_tail] = c.tid;
                    mb_tail  = mb_tail + 1'b1;
                    mb_count = mb_count + 1'b1;
                    expected_results.push_back(make_result(ST_BLOCKED, 1'b0, '0, '0, 1'b1));
                end
            end
            default: begin
                expected_results.push_back(make_result(ST_NO_WAITERS, 1'b0, '0, '0, 1'b1));
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Sample both channels: check results, then mirror accepted commands
    always @(posedge aclk) begin
        res_t want;
        mbox_cmd_t c;
        if (!aresetn) begin
            mb_slot_full  = 1'b0;
            mb_slot_value = '0;
            mb_head       = '0;
            mb_tail       = '0;
            mb_count      = '0;
            in_taken      = 1'b0;
            idle_cycles   = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, actual tuser %h tdata %h tlast %b",
                             $time, m_tuser, m_tdata, m_tlast);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(m_tuser[2:0]));
                    check_field("delivery_valid", 32'(want.dv), 32'(m_tuser[3]));
                    check_field("target_thread", 32'(want.target), 32'(m_tdata[5:0]));
                    check_field("delivered_value", want.value, m_tdata[37:6]);
                    check_field("last", 32'(want.last), 32'(m_tlast));
                end
            end
            in_taken = s_tvalid && s_tready;
            if (in_taken) begin
                c.cmd   = cmd_code_t'(s_tuser);
                c.tid   = s_tdata[5:0];
                c.value = s_tdata[37:6];
                predict_mailbox(c);
            end
            // Watchdog: count cycles without any transfer
            if (in_taken || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Command driver: hold until accepted, then insert a gap or present the next item
    always @(negedge aclk) begin
        mbox_cmd_t c;
        if (aresetn) begin
            if (!s_tvalid || in_taken) begin
                if (in_taken) begin
                    in_gap = calm ? 0 : pick_gap();
                end
                if (in_gap > 0) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    c = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= c.cmd;
                    s_tdata  <= {2'b00, c.value, c.tid};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result-side backpressure, with calm stretches chosen now and then
    always @(negedge aclk) begin
        if (aresetn) begin
            phase_cnt++;
            if (phase_cnt % 100 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            if (out_stall > 0) begin
                out_stall--;
                m_tready <= 1'b0;
            end else begin
                out_stall = calm ? 0 : pick_gap();
                m_tready <= (out_stall == 0);
                if (out_stall > 0) out_stall--;
            end
        end
    end

    task automatic add_cmd(input cmd_code_t cmd, input logic [TID_W-1:0] tid,
                           input logic [VAL_W-1:0] value);
        mbox_cmd_t c;
        c.cmd   = cmd;
        c.tid   = tid;
        c.value = value;
        pending_cmds.push_back(c);
        item_count++;
    endtask

    // One random phase: a run of receives followed by one or more closing commands
    task automatic add_random_phase();
        int r;
        int waiters;
        r = $urandom_range(0, 9);
        if (r < 3) waiters = $urandom_range(0, 3);
        else if (r < 8) waiters = $urandom_range(4, 16);
        else waiters = 17;
        repeat (waiters) add_cmd(CMD_RECV, $urandom_range(0, 63), $urandom);
        r = $urandom_range(0, 9);
        if (r < 4) begin
            add_cmd(CMD_BCAST, $urandom_range(0, 63), $urandom);
        end else if (r < 7) begin
            add_cmd(CMD_SEND, $urandom_range(0, 63), $urandom);
        end else if (r == 7) begin
            add_cmd(CMD_SEND, $urandom_range(0, 63), $urandom);
            add_cmd(CMD_RECV, $urandom_range(0, 63), $urandom);
        end else if (r == 8) begin
            add_cmd(CMD_SEND, $urandom_range(0, 63), $urandom);
            add_cmd(CMD_SEND, $urandom_range(0, 63), $urandom);
            add_cmd(CMD_BCAST, $urandom_range(0, 63), $urandom);
        end else begin
            add_cmd(cmd_code_t'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom);
        end
    endtask

    // Reset, stimulus, drain and verdict
    initial begin
        int i;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;

        // Directed: every command, both slot states, empty and full waiter queue
        add_cmd(CMD_RECV,  6'd0,  32'h0000_0000);   // block on empty slot
        add_cmd(CMD_SEND,  6'd5,  32'h7fff_ffff);   // hand straight to waiter
        add_cmd(CMD_SEND,  6'd63, 32'h8000_0000);   // store in empty slot
        add_cmd(CMD_SEND,  6'd1,  32'hffff_ffff);   // slot already full
        add_cmd(CMD_BCAST, 6'd2,  32'h1234_5678);   // broadcast with slot full
        add_cmd(CMD_RECV,  6'd63, 32'hffff_ffff);   // take stored value
        add_cmd(CMD_BCAST, 6'd3,  32'h0000_0001);   // nobody waiting
        add_cmd(CMD_BAD,   6'd63, 32'hffff_ffff);   // unknown command
        for (i = 0; i < WAITER_SLOTS; i++) begin
            add_cmd(CMD_RECV, 6'(i * 4 + 3), $urandom);
        end
        add_cmd(CMD_RECV,  6'd42, 32'h5555_aaaa);   // waiter queue overflow
        add_cmd(CMD_BCAST, 6'd7,  32'h8000_0001);   // drain all sixteen waiters

        // Random phases up to the overall item budget
        while (item_count < TOTAL_ITEMS) add_random_phase();

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        // Wait for all stimulus, then all results, then a quiet tail
        while (pending_cmds.size() > 0 || s_tvalid) @(posedge aclk);
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
